>>> hw/rtl/tlqe_pkg.sv
// ----------------------------------------------------------------------------
// tlqe_pkg
// Shared types, widths and arithmetic helpers of the thick line quad expander.
// ----------------------------------------------------------------------------
package tlqe_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 4;

    // difference, magnitude and derived widths
    localparam int DW    = COORD_BITS + 1;
    localparam int RADW  = 2 * COORD_BITS + 2;
    localparam int REMW  = COORD_BITS + 3;
    localparam int DSHW  = COORD_BITS + 16;
    localparam int DNW   = COORD_BITS + 17;
    localparam int CNTW  = $clog2(COORD_BITS + 2);
    localparam int AW    = FRAC_BITS + 10;
    localparam int PW    = FRAC_BITS + 26;
    localparam int CW    = COORD_BITS + 3;

    localparam logic signed [CW-1:0] CMAX = CW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [CW-1:0] CMIN = CW'(-(64'sd1 <<< (COORD_BITS - 1)));

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x_start;
        logic signed [COORD_BITS-1:0] y_start;
        logic signed [COORD_BITS-1:0] x_end;
        logic signed [COORD_BITS-1:0] y_end;
        logic [7:0]                   line_width;
        logic [7:0]                   red_in;
        logic [7:0]                   green_in;
        logic [7:0]                   blue_in;
        logic [7:0]                   alpha_in;
        logic                         final_line;
    } t_line_in;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vertex_x;
        logic signed [COORD_BITS-1:0] vertex_y;
        logic [7:0]                   red_out;
        logic [7:0]                   green_out;
        logic [7:0]                   blue_out;
        logic [7:0]                   alpha_out;
        logic [2:0]                   corner_index;
        logic                         last_vertex;
        logic                         batch_end;
    } t_vertex;

    // classified segment handed from front to back
    typedef struct packed {
        t_line_in             line;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
    } t_seg;

    // round(q * (w + 1) * 2^FRAC_BITS / 2^16), half away from zero
    function automatic logic signed [AW-1:0] axial_off(input logic [15:0] q,
                                                      input logic        neg,
                                                      input logic [7:0]  w);
        logic [24:0]   prod;
        logic [PW-1:0] t;
        logic [AW-1:0] r;
        prod = q * ({1'b0, w} + 9'd1);
        t    = (PW'(prod) << FRAC_BITS) + PW'(32'd32768);
        r    = t[PW-1:16];
        return neg ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [COORD_BITS-1:0] sat_coord(
        input logic signed [CW-1:0] v);
        if (v > CMAX) begin
            return CMAX[COORD_BITS-1:0];
        end else if (v < CMIN) begin
            return CMIN[COORD_BITS-1:0];
        end
        return v[COORD_BITS-1:0];
    endfunction

    function automatic logic signed [CW-1:0] sext_c(
        input logic signed [COORD_BITS-1:0] v);
        return {{(CW-COORD_BITS){v[COORD_BITS-1]}}, v};
    endfunction

    function automatic logic signed [CW-1:0] sext_a(input logic signed [AW-1:0] v);
        return {{(CW-AW){v[AW-1]}}, v};
    endfunction

endpackage

>>> hw/rtl/tlqe_front.sv
// ----------------------------------------------------------------------------
// tlqe_front
// Accepts line transactions, forms the endpoint differences, drops
// zero-length lines and holds the rest in a two-entry queue.
// ----------------------------------------------------------------------------
module tlqe_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    input  tlqe_pkg::t_line_in i_line,
    output logic              full,
    input  logic              i_seg_pop,
    output logic              o_seg_empty,
    output tlqe_pkg::t_seg    o_seg
);
    import tlqe_pkg::*;

    t_seg       r_slot [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       n_wr, n_rd;
    logic [1:0] n_cnt;
    t_seg       seg_in;
    logic       acc, wr_en, rd_en;

    always_comb begin
        seg_in.line = i_line;
        seg_in.dx   = DW'(i_line.x_end) - DW'(i_line.x_start);
        seg_in.dy   = DW'(i_line.y_end) - DW'(i_line.y_start);
    end

    assign full        = (r_cnt == 2'd2);
    assign o_seg_empty = (r_cnt == 2'd0);
    assign o_seg       = r_slot[r_rd];
    assign acc         = push && !full;
    // drop zero-length lines here
    assign wr_en       = acc && ((seg_in.dx != '0) || (seg_in.dy != '0));
    assign rd_en       = i_seg_pop && !o_seg_empty;

    always_comb begin
        n_wr  = wr_en ? ~r_wr : r_wr;
        n_rd  = rd_en ? ~r_rd : r_rd;
        n_cnt = r_cnt + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot[r_wr] <= seg_in;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count out of range");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1) |-> (r_wr != r_rd)) else $error("pointer mismatch");
    a_zero_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && seg_in.dx == '0 && seg_in.dy == '0 && !rd_en) |=>
        (r_cnt == $past(r_cnt))) else $error("zero-length line queued");
`endif

endmodule

>>> hw/rtl/tlqe_back.sv
// ----------------------------------------------------------------------------
// tlqe_back
// Computes length, unit direction and offsets of one segment with an
// iterative root and two shared-step dividers, then emits six vertices.
// ----------------------------------------------------------------------------
module tlqe_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_seg_empty,
    input  tlqe_pkg::t_seg    i_seg,
    output logic              o_seg_pop,
    output logic              empty,
    input  logic              pop,
    output tlqe_pkg::t_vertex o_vertex
);
    import tlqe_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;
    localparam logic [2:0] S_ROOT = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_AX   = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0]             r_state;
    logic [CNTW-1:0]        r_cnt;
    logic [2:0]             r_k;
    t_seg                   r_seg;
    logic [DW-1:0]          r_mx, r_my;
    logic [RADW-1:0]        r_rad;
    logic [DW-1:0]          r_root;
    logic [REMW-1:0]        r_rem;
    logic [DSHW-1:0]        r_dsh;
    logic [DNW-1:0]         r_nx, r_ny;
    logic [15:0]            r_qx, r_qy;
    logic signed [AW-1:0]   r_ax, r_ay;
    logic                   r_ov;
    t_vertex                r_ovtx;

    logic [REMW+1:0]        rem_n, trial;
    logic                   bx, by, emit_go, at_start, nsign;
    logic signed [CW-1:0]   bxc, byc, vx, vy;
    t_vertex                vtx;

    assign o_seg_pop = (r_state == S_IDLE) && !i_seg_empty;
    assign empty     = !r_ov;
    assign o_vertex  = r_ovtx;
    assign emit_go   = (r_state == S_EMIT) && (!r_ov || pop);

    assign rem_n = {r_rem, r_rad[RADW-1 -: 2]};
    assign trial = {2'b00, r_root, 2'b01};
    assign bx    = (r_nx >= {1'b0, r_dsh});
    assign by    = (r_ny >= {1'b0, r_dsh});

    // corner k: end point and normal sign
    always_comb begin
        case (r_k)
            3'd0:    begin at_start = 1'b1; nsign = 1'b0; end
            3'd1:    begin at_start = 1'b1; nsign = 1'b1; end
            3'd2:    begin at_start = 1'b0; nsign = 1'b0; end
            3'd3:    begin at_start = 1'b1; nsign = 1'b1; end
            3'd4:    begin at_start = 1'b0; nsign = 1'b1; end
            default: begin at_start = 1'b0; nsign = 1'b0; end
        endcase
        bxc = at_start ? sext_c(r_seg.line.x_start) - sext_a(r_ax)
                       : sext_c(r_seg.line.x_end) + sext_a(r_ax);
        byc = at_start ? sext_c(r_seg.line.y_start) - sext_a(r_ay)
                       : sext_c(r_seg.line.y_end) + sext_a(r_ay);
        vx  = nsign ? bxc + sext_a(r_ay) : bxc - sext_a(r_ay);
        vy  = nsign ? byc - sext_a(r_ax) : byc + sext_a(r_ax);
        vtx.vertex_x     = sat_coord(vx);
        vtx.vertex_y     = sat_coord(vy);
        vtx.red_out      = r_seg.line.red_in;
        vtx.green_out    = r_seg.line.green_in;
        vtx.blue_out     = r_seg.line.blue_in;
        vtx.alpha_out    = r_seg.line.alpha_in;
        vtx.corner_index = r_k;
        vtx.last_vertex  = (r_k == 3'd5);
        vtx.batch_end    = (r_k == 3'd5) && r_seg.line.final_line;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_k     <= 3'd0;
            r_ov    <= 1'b0;
        end else begin
            if (emit_go) begin
                r_ov <= 1'b1;
            end else if (pop) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_seg_empty) begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_cnt   <= CNTW'(COORD_BITS);
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_cnt   <= CNTW'(15);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_AX;
                    end
                end
                S_AX: begin
                    r_k     <= 3'd0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (emit_go) begin
                        r_k <= r_k + 3'd1;
                        if (r_k == 3'd5) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_ovtx <= vtx;
        end
        case (r_state)
            S_IDLE: begin
                r_seg <= i_seg;
                r_mx  <= i_seg.dx[DW-1] ? DW'(-i_seg.dx) : DW'(i_seg.dx);
                r_my  <= i_seg.dy[DW-1] ? DW'(-i_seg.dy) : DW'(i_seg.dy);
            end
            S_SQ: begin
                r_rad  <= RADW'(r_mx * r_mx) + RADW'(r_my * r_my);
                r_root <= '0;
                r_rem  <= '0;
            end
            S_ROOT: begin
                // one root bit per step
                r_rad <= r_rad << 2;
                if (rem_n >= trial) begin
                    r_rem  <= REMW'(rem_n - trial);
                    r_root <= {r_root[DW-2:0], 1'b1};
                end else begin
                    r_rem  <= REMW'(rem_n);
                    r_root <= {r_root[DW-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    r_nx <= DNW'({r_mx, 15'd0}) + DNW'(rem_n >= trial ?
                            {r_root[DW-2:0], 1'b1} : {r_root[DW-2:0], 1'b0}) / 2;
                    r_ny <= DNW'({r_my, 15'd0}) + DNW'(rem_n >= trial ?
                            {r_root[DW-2:0], 1'b1} : {r_root[DW-2:0], 1'b0}) / 2;
                    r_dsh <= {(rem_n >= trial) ? {r_root[DW-2:0], 1'b1}
                                               : {r_root[DW-2:0], 1'b0}, 15'd0};
                end
            end
            S_DIV: begin
                // one quotient bit per step on both axes
                if (bx) begin
                    r_nx <= r_nx - DNW'(r_dsh);
                end
                if (by) begin
                    r_ny <= r_ny - DNW'(r_dsh);
                end
                r_qx  <= {r_qx[14:0], bx};
                r_qy  <= {r_qy[14:0], by};
                r_dsh <= r_dsh >> 1;
            end
            S_AX: begin
                r_ax <= axial_off(r_qx, r_seg.dx[DW-1], r_seg.line.line_width);
                r_ay <= axial_off(r_qy, r_seg.dy[DW-1], r_seg.line.line_width);
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_k <= 3'd5)) else $error("corner out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !pop) |=> (r_ov && $stable(r_ovtx))) else $error("vertex lost");
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dsh != '0)) else $error("zero length at divide");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ovtx.last_vertex) |-> (r_ovtx.corner_index == 3'd5))
        else $error("last vertex mismatch");
`endif

endmodule

>>> hw/rtl/thick_line_quad_expander_top.sv
// ----------------------------------------------------------------------------
// thick_line_quad_expander_top
// Expands line segments into the six vertices of a square-capped quad.
// ----------------------------------------------------------------------------
// Each line transaction yields six vertex transactions (two triangles), or
// none for a zero-length line, which is dropped at the input. In the back
// end a line passes through one load, one square, COORD_BITS+1 root steps,
// 16 divide steps, one offset step and the emission of six vertices, which
// can stall while the output holds an unpopped vertex. A two-entry
// queue lets new lines enter while a line is computed and its vertices wait.
module thick_line_quad_expander_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  tlqe_pkg::t_line_in i_line,
    output logic               full,
    output logic               empty,
    input  logic               pop,
    output tlqe_pkg::t_vertex  o_vertex
);
    import tlqe_pkg::*;

    logic seg_pop, seg_empty;
    t_seg seg;

    tlqe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_line      (i_line),
        .full        (full),
        .i_seg_pop   (seg_pop),
        .o_seg_empty (seg_empty),
        .o_seg       (seg)
    );

    tlqe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seg_empty (seg_empty),
        .i_seg       (seg),
        .o_seg_pop   (seg_pop),
        .empty       (empty),
        .pop         (pop),
        .o_vertex    (o_vertex)
    );

endmodule
